@@ rtl/wpid_pkg.sv @@
// shared types and constants of the windowed pid controller
package wpid_pkg;

    localparam int ANGLE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DER_W     = 18;
    localparam int DRIVE_W   = 21;
    localparam int FRAC_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] SET_POINT_RST  = 16'd48128;
    localparam logic [15:0] KP_GAIN_RST    = 16'd20480;
    localparam logic [15:0] KI_GAIN_RST    = 16'd123;
    localparam logic [15:0] KD_GAIN_RST    = 16'd2048;
    localparam logic [15:0] ANGLE_LOW_RST  = 16'd35840;
    localparam logic [15:0] ANGLE_HIGH_RST = 16'd58880;
    localparam logic [15:0] DEAD_BAND_RST  = 16'd10;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_NORMAL      = 2'd0,
        ST_OUT_OF_BAND = 2'd1,
        ST_FIRST       = 2'd2,
        ST_DEAD_BAND   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_POINT  = 3'd0,
        REG_KP_GAIN    = 3'd1,
        REG_KI_GAIN    = 3'd2,
        REG_KD_GAIN    = 3'd3,
        REG_ANGLE_LOW  = 3'd4,
        REG_ANGLE_HIGH = 3'd5,
        REG_DEAD_BAND  = 3'd6
    } t_cfg_index;

endpackage

@@ rtl/wpid_intf.sv @@
// stream and configuration interfaces of the windowed pid controller
interface wpid_angle_if;
    logic                         valid;
    logic                         ready;
    logic [wpid_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface wpid_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [wpid_pkg::DRIVE_W-1:0] drive;
    wpid_pkg::t_status                   status;

    modport source (output valid, output drive, output status, input ready);
    modport sink   (input valid, input drive, input status, output ready);
endinterface

interface wpid_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wpid_pkg::CFG_IDX_W-1:0]  index;
    logic [wpid_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/windowed_pid_controller.sv @@
// top level of the windowed pid controller
// Takes one unsigned Q8.8 angle item per cycle while the result side keeps up and returns
// one drive/status item per input, in order. Sustained rate is one item per clock unless the
// result side stalls; from acceptance to a valid result an item goes through error and window
// update out of the input register, gain products, accumulation, and truncation/saturation/
// deadband into the output register. The only item-to-item dependency is the error and
// window-sum update, one add per cycle in the second stage. Each stage holds its item until
// the next one frees up, so bubbles are squeezed out and new items keep entering while a
// result waits, until every stage is full. The error window is a shift line of WINDOW taps
// cleared by reset; no clearing pass is needed. Configuration writes are taken in any cycle
// out of reset and must only be issued while the pipeline is empty.
module windowed_pid_controller #(
    parameter int WINDOW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wpid_angle_if.sink    i_angle_ch,
    wpid_result_if.source o_result_ch,
    wpid_cfg_if.sink      i_cfg_ch
);

    localparam int ERR_W   = wpid_pkg::ERR_W;
    localparam int DER_W   = wpid_pkg::DER_W;
    localparam int GAIN_W  = wpid_pkg::GAIN_W;
    localparam int DRIVE_W = wpid_pkg::DRIVE_W;
    localparam int FRAC_W  = wpid_pkg::FRAC_W;
    localparam int SUM_W   = ERR_W + $clog2(WINDOW);
    localparam int PKP_W   = GAIN_W + 1 + ERR_W;
    localparam int PKI_W   = GAIN_W + 1 + SUM_W;
    localparam int PKD_W   = GAIN_W + 1 + DER_W;
    localparam int ACC_A   = SUM_W + 19;
    localparam int ACC_B   = FRAC_W + DRIVE_W + 1;
    localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int Q_W     = ACC_W - FRAC_W;

    // configuration registers
    logic [15:0] r_set_point;
    logic [15:0] r_kp_gain;
    logic [15:0] r_ki_gain;
    logic [15:0] r_kd_gain;
    logic [15:0] r_angle_low;
    logic [15:0] r_angle_high;
    logic [15:0] r_dead_band;

    // controller state
    logic                    r_first_pending;
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [SUM_W-1:0] r_window_sum;
    logic signed [ERR_W-1:0] r_ring [WINDOW];

    // pipeline control
    logic [3:0] r_valid;
    logic [3:0] adv;
    logic       out_free;
    logic       in_acc;
    logic       r_out_valid;

    // stage payloads
    logic [wpid_pkg::ANGLE_W-1:0] r_angle;
    logic signed [ERR_W-1:0]      r_err1;
    logic signed [SUM_W-1:0]      r_sum1;
    logic signed [DER_W-1:0]      r_der1;
    wpid_pkg::t_status            r_st1;
    logic signed [PKP_W-1:0]      r_pkp;
    logic signed [PKI_W-1:0]      r_pki;
    logic signed [PKD_W-1:0]      r_pkd;
    wpid_pkg::t_status            r_st2;
    logic signed [ACC_W-1:0]      r_acc;
    wpid_pkg::t_status            r_st3;
    logic signed [DRIVE_W-1:0]    r_drive;
    wpid_pkg::t_status            r_status;

    // update stage next values
    logic signed [ERR_W-1:0] n_err;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DER_W-1:0] n_der;
    wpid_pkg::t_status       n_st;
    logic                    out_of_band;

    // final stage next values
    logic signed [Q_W-1:0]     q_floor;
    logic signed [Q_W-1:0]     q_trunc;
    logic signed [DRIVE_W-1:0] drv_sat;
    logic [DRIVE_W-1:0]        drv_mag;
    logic signed [DRIVE_W-1:0] n_drive;
    wpid_pkg::t_status         n_status;

    // handshake and stage advance
    always_comb begin
        out_free = !r_out_valid || o_result_ch.ready;
        adv[3]   = r_valid[3] && out_free;
        adv[2]   = r_valid[2] && (!r_valid[3] || adv[3]);
        adv[1]   = r_valid[1] && (!r_valid[2] || adv[2]);
        adv[0]   = r_valid[0] && (!r_valid[1] || adv[1]);
    end

    assign i_angle_ch.ready = i_rst_n && (!r_valid[0] || adv[0]);
    assign in_acc           = i_angle_ch.valid && i_angle_ch.ready;
    assign i_cfg_ch.ready   = i_rst_n;

    assign o_result_ch.valid  = r_out_valid;
    assign o_result_ch.drive  = r_drive;
    assign o_result_ch.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_valid[0] <= 1'b1;
            end else if (adv[0]) begin
                r_valid[0] <= 1'b0;
            end
            for (int k = 1; k < 4; k++) begin
                if (adv[k-1]) begin
                    r_valid[k] <= 1'b1;
                end else if (adv[k]) begin
                    r_valid[k] <= 1'b0;
                end
            end
            if (adv[3]) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_point  <= wpid_pkg::SET_POINT_RST;
            r_kp_gain    <= wpid_pkg::KP_GAIN_RST;
            r_ki_gain    <= wpid_pkg::KI_GAIN_RST;
            r_kd_gain    <= wpid_pkg::KD_GAIN_RST;
            r_angle_low  <= wpid_pkg::ANGLE_LOW_RST;
            r_angle_high <= wpid_pkg::ANGLE_HIGH_RST;
            r_dead_band  <= wpid_pkg::DEAD_BAND_RST;
        end else if (i_cfg_ch.valid) begin
            case (wpid_pkg::t_cfg_index'(i_cfg_ch.index))
                wpid_pkg::REG_SET_POINT:  r_set_point  <= i_cfg_ch.data;
                wpid_pkg::REG_KP_GAIN:    r_kp_gain    <= i_cfg_ch.data;
                wpid_pkg::REG_KI_GAIN:    r_ki_gain    <= i_cfg_ch.data;
                wpid_pkg::REG_KD_GAIN:    r_kd_gain    <= i_cfg_ch.data;
                wpid_pkg::REG_ANGLE_LOW:  r_angle_low  <= i_cfg_ch.data;
                wpid_pkg::REG_ANGLE_HIGH: r_angle_high <= i_cfg_ch.data;
                wpid_pkg::REG_DEAD_BAND:  r_dead_band  <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_angle <= i_angle_ch.angle;
        end
    end

    // error, band check and window update
    always_comb begin
        n_err       = $signed({1'b0, r_set_point}) - $signed({1'b0, r_angle});
        out_of_band = (r_angle < r_angle_low) || (r_angle > r_angle_high);
        n_sum       = r_window_sum - SUM_W'(r_ring[WINDOW-1]) + SUM_W'(n_err);
        n_der       = DER_W'(n_err) - DER_W'(r_prev_err);
        if (out_of_band) begin
            n_st = wpid_pkg::ST_OUT_OF_BAND;
        end else if (r_first_pending) begin
            n_st = wpid_pkg::ST_FIRST;
        end else begin
            n_st = wpid_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pending <= 1'b1;
            r_prev_err      <= '0;
            r_window_sum    <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
        end else if (adv[0]) begin
            r_prev_err <= n_err;
            if (!out_of_band) begin
                r_first_pending <= 1'b0;
                if (!r_first_pending) begin
                    r_window_sum <= n_sum;
                    r_ring[0]    <= n_err;
                    for (int k = 1; k < WINDOW; k++) begin
                        r_ring[k] <= r_ring[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_err1 <= n_err;
            r_sum1 <= n_sum;
            r_der1 <= n_der;
            r_st1  <= n_st;
        end
    end

    // gain products
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_pkp <= $signed({1'b0, r_kp_gain}) * r_err1;
            r_pki <= $signed({1'b0, r_ki_gain}) * r_sum1;
            r_pkd <= $signed({1'b0, r_kd_gain}) * r_der1;
            r_st2 <= r_st1;
        end
    end

    // accumulation
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_acc <= ACC_W'(r_pkp) + ACC_W'(r_pki) - ACC_W'(r_pkd);
            r_st3 <= r_st2;
        end
    end

    // truncate toward zero, saturate, deadband
    always_comb begin
        q_floor = r_acc[ACC_W-1:FRAC_W];
        if (r_acc[ACC_W-1] && (r_acc[FRAC_W-1:0] != '0)) begin
            q_trunc = q_floor + Q_W'(1);
        end else begin
            q_trunc = q_floor;
        end
        if (q_trunc[Q_W-1:DRIVE_W-1] == '0 || q_trunc[Q_W-1:DRIVE_W-1] == '1) begin
            drv_sat = q_trunc[DRIVE_W-1:0];
        end else if (q_trunc[Q_W-1]) begin
            drv_sat = wpid_pkg::DRIVE_MIN;
        end else begin
            drv_sat = wpid_pkg::DRIVE_MAX;
        end
        drv_mag = drv_sat[DRIVE_W-1] ? (~drv_sat + DRIVE_W'(1)) : drv_sat;
        if (r_st3 != wpid_pkg::ST_NORMAL) begin
            n_drive  = '0;
            n_status = r_st3;
        end else if (drv_mag < DRIVE_W'(r_dead_band)) begin
            n_drive  = '0;
            n_status = wpid_pkg::ST_DEAD_BAND;
        end else begin
            n_drive  = drv_sat;
            n_status = wpid_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_drive  <= n_drive;
            r_status <= n_status;
        end
    end

endmodule

@@ tb/windowed_pid_controller_test.sv @@
// self-checking testbench of the windowed pid controller: directed table, random phases
module windowed_pid_controller_test;

    localparam int WIN_LEN      = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_LEN     = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 285;
    localparam int EMPTY_ITEMS  = 50;
    localparam int CALM_PHASE   = 2;
    localparam int HOLD_PHASE   = 4;
    localparam int EMPTY_PHASE  = 5;
    localparam int IDLE_PERCENT = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int PLAN_LEN     = 37;

    localparam logic [wpid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint DRIVE_TOP = (longint'(1) << (wpid_pkg::DRIVE_W - 1)) - 1;
    localparam longint DRIVE_BOT = -(longint'(1) << (wpid_pkg::DRIVE_W - 1));

    typedef struct packed {
        logic signed [wpid_pkg::DRIVE_W-1:0] drive;
        wpid_pkg::t_status                   status;
    } t_drive_item;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [wpid_pkg::CFG_IDX_W-1:0] index;
        logic [wpid_pkg::ANGLE_W-1:0]   value;
        bit                             typed;
        t_drive_item                    result;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    wpid_angle_if  angle_ch ();
    wpid_result_if result_ch ();
    wpid_cfg_if    cfg_ch ();

    windowed_pid_controller #(
        .WINDOW(WIN_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_angle_ch (angle_ch),
        .o_result_ch(result_ch),
        .i_cfg_ch   (cfg_ch)
    );

    // controller state as the block should hold it
    logic [15:0] reg_shadow [7];
    bit          awaiting_first;
    int          prev_err;
    int          win_sum;
    int          err_ring [WIN_LEN];
    int          ring_pos;

    t_drive_item expected_drive_q [$];
    int          mismatches;
    int          cycle_count;
    bit          calm_run;
    bit          hold_request;
    int          hold_left;
    t_drive_item want_item;
    t_row        plan [PLAN_LEN];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("windowed_pid_controller_test NOT OK");
        $finish;
    end

    function automatic t_row item_row(input logic [15:0] a);
        t_row r;
        r.kind   = ROW_ITEM;
        r.index  = wpid_pkg::REG_SET_POINT;
        r.value  = a;
        r.typed  = 1'b0;
        r.result = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [15:0] a, input wpid_pkg::t_status st);
        t_row r;
        r = item_row(a);
        r.typed = 1'b1;
        r.result.drive = '0;
        r.result.status = st;
        return r;
    endfunction

    function automatic t_row write_row(input logic [wpid_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [15:0] v);
        t_row r;
        r = item_row(v);
        r.kind  = ROW_WRITE;
        r.index = idx;
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_drive_item pid_step(input logic [15:0] a);
        t_drive_item r;
        int          e;
        longint      der;
        longint      acc;
        longint      drv;
        longint      mag;
        r.drive  = '0;
        r.status = wpid_pkg::ST_NORMAL;
        e = int'(reg_shadow[wpid_pkg::REG_SET_POINT]) - int'(a);
        if (a < reg_shadow[wpid_pkg::REG_ANGLE_LOW]
            || a > reg_shadow[wpid_pkg::REG_ANGLE_HIGH]) begin
            prev_err = e;
            r.status = wpid_pkg::ST_OUT_OF_BAND;
            return r;
        end
        if (awaiting_first) begin
            prev_err = e;
            awaiting_first = 1'b0;
            r.status = wpid_pkg::ST_FIRST;
            return r;
        end
        win_sum = win_sum - err_ring[ring_pos] + e;
        err_ring[ring_pos] = e;
        ring_pos = (ring_pos + 1 >= WIN_LEN) ? 0 : ring_pos + 1;
        der = longint'(e) - longint'(prev_err);
        prev_err = e;
        acc = longint'(reg_shadow[wpid_pkg::REG_KP_GAIN]) * e
            + longint'(reg_shadow[wpid_pkg::REG_KI_GAIN]) * win_sum
            - longint'(reg_shadow[wpid_pkg::REG_KD_GAIN]) * der;
        drv = (acc < 0) ? -((-acc) >>> wpid_pkg::FRAC_W) : (acc >>> wpid_pkg::FRAC_W);
        if (drv > DRIVE_TOP) drv = DRIVE_TOP;
        if (drv < DRIVE_BOT) drv = DRIVE_BOT;
        mag = (drv < 0) ? -drv : drv;
        if (mag < longint'(reg_shadow[wpid_pkg::REG_DEAD_BAND])) begin
            r.status = wpid_pkg::ST_DEAD_BAND;
            return r;
        end
        r.drive = drv[wpid_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic send_angle(input logic [15:0] a, input bit typed, input t_drive_item fixed);
        t_drive_item predicted;
        if (!calm_run && $urandom_range(99) < IDLE_PERCENT) begin
            angle_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= a;
        @(posedge i_clk);
        while (!angle_ch.ready) @(posedge i_clk);
        predicted = pid_step(a);
        expected_drive_q.push_back(typed ? fixed : predicted);
    endtask

    task automatic write_reg(input logic [wpid_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx <= wpid_pkg::REG_DEAD_BAND) begin
            reg_shadow[idx] = v;
        end
    endtask

    task automatic wait_for_drain();
        angle_ch.valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_phase(input int ph);
        logic [15:0] a;
        logic [15:0] b;
        if (ph == 0) begin
            write_reg(wpid_pkg::REG_SET_POINT, wpid_pkg::SET_POINT_RST);
            write_reg(wpid_pkg::REG_KP_GAIN, wpid_pkg::KP_GAIN_RST);
            write_reg(wpid_pkg::REG_KI_GAIN, wpid_pkg::KI_GAIN_RST);
            write_reg(wpid_pkg::REG_KD_GAIN, wpid_pkg::KD_GAIN_RST);
            write_reg(wpid_pkg::REG_ANGLE_LOW, wpid_pkg::ANGLE_LOW_RST);
            write_reg(wpid_pkg::REG_ANGLE_HIGH, wpid_pkg::ANGLE_HIGH_RST);
            write_reg(wpid_pkg::REG_DEAD_BAND, wpid_pkg::DEAD_BAND_RST);
        end else begin
            a = pick_value();
            b = pick_value();
            if (ph == EMPTY_PHASE) begin
                a = a | 16'h8000;
                b = b & 16'h7FFF;
            end else if (a > b) begin
                {a, b} = {b, a};
            end
            write_reg(wpid_pkg::REG_SET_POINT, pick_value());
            write_reg(wpid_pkg::REG_KP_GAIN, pick_value());
            write_reg(wpid_pkg::REG_KI_GAIN, pick_value());
            write_reg(wpid_pkg::REG_KD_GAIN, pick_value());
            write_reg(wpid_pkg::REG_ANGLE_LOW, a);
            write_reg(wpid_pkg::REG_ANGLE_HIGH, b);
            write_reg(wpid_pkg::REG_DEAD_BAND,
                      ($urandom_range(3) == 0) ? pick_value() : 16'($urandom_range(0, 300)));
            write_reg(REG_UNUSED, 16'($urandom));
        end
    endtask

    function automatic logic [15:0] next_angle();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = reg_shadow[wpid_pkg::REG_ANGLE_LOW];
        hi = reg_shadow[wpid_pkg::REG_ANGLE_HIGH];
        if (lo <= hi && $urandom_range(99) < 85) begin
            return 16'($urandom_range(hi, lo));
        end
        return 16'($urandom);
    endfunction

    // result side: checks every item taken, idles at random and holds off when a hold is requested
    initial begin
        result_ch.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                if (expected_drive_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected result drive %0d status %0d",
                                           result_ch.drive, result_ch.status));
                end else begin
                    want_item = expected_drive_q.pop_front();
                    if (result_ch.drive !== want_item.drive
                        || result_ch.status !== want_item.status) begin
                        log_mismatch($sformatf(
                            "mismatch drive exp %0d got %0d, status exp %0d got %0d",
                            want_item.drive, result_ch.drive,
                            want_item.status, result_ch.status));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_LEN - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= calm_run || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        angle_ch.valid <= 1'b0;
        angle_ch.angle <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= wpid_pkg::REG_SET_POINT;
        cfg_ch.data    <= '0;
        i_rst_n        <= 1'b0;
        mismatches     = 0;
        calm_run       = 1'b0;
        hold_request   = 1'b0;

        reg_shadow[wpid_pkg::REG_SET_POINT]  = wpid_pkg::SET_POINT_RST;
        reg_shadow[wpid_pkg::REG_KP_GAIN]    = wpid_pkg::KP_GAIN_RST;
        reg_shadow[wpid_pkg::REG_KI_GAIN]    = wpid_pkg::KI_GAIN_RST;
        reg_shadow[wpid_pkg::REG_KD_GAIN]    = wpid_pkg::KD_GAIN_RST;
        reg_shadow[wpid_pkg::REG_ANGLE_LOW]  = wpid_pkg::ANGLE_LOW_RST;
        reg_shadow[wpid_pkg::REG_ANGLE_HIGH] = wpid_pkg::ANGLE_HIGH_RST;
        reg_shadow[wpid_pkg::REG_DEAD_BAND]  = wpid_pkg::DEAD_BAND_RST;
        awaiting_first = 1'b1;
        prev_err = 0;
        win_sum  = 0;
        ring_pos = 0;
        foreach (err_ring[k]) err_ring[k] = 0;

        plan = '{
            typed_row(16'd0, wpid_pkg::ST_OUT_OF_BAND),
            typed_row(16'hFFFF, wpid_pkg::ST_OUT_OF_BAND),
            typed_row(16'd48128, wpid_pkg::ST_FIRST),
            typed_row(16'd48128, wpid_pkg::ST_DEAD_BAND),
            item_row(16'd35840),
            item_row(16'd58880),
            typed_row(16'd35839, wpid_pkg::ST_OUT_OF_BAND),
            typed_row(16'd58881, wpid_pkg::ST_OUT_OF_BAND),
            item_row(16'd40000),
            write_row(wpid_pkg::REG_SET_POINT, 16'hFFFF),
            write_row(wpid_pkg::REG_KP_GAIN, 16'hFFFF),
            write_row(wpid_pkg::REG_KI_GAIN, 16'hFFFF),
            write_row(wpid_pkg::REG_KD_GAIN, 16'h0000),
            write_row(wpid_pkg::REG_ANGLE_LOW, 16'h0000),
            write_row(wpid_pkg::REG_ANGLE_HIGH, 16'hFFFF),
            write_row(wpid_pkg::REG_DEAD_BAND, 16'h0000),
            item_row(16'd0),
            item_row(16'd0),
            item_row(16'hFFFF),
            write_row(wpid_pkg::REG_SET_POINT, 16'h0000),
            write_row(wpid_pkg::REG_KD_GAIN, 16'hFFFF),
            item_row(16'hFFFF),
            item_row(16'd0),
            item_row(16'hFFFF),
            write_row(wpid_pkg::REG_KP_GAIN, 16'h0000),
            write_row(wpid_pkg::REG_KI_GAIN, 16'h0000),
            write_row(wpid_pkg::REG_KD_GAIN, 16'h0000),
            typed_row(16'd12345, wpid_pkg::ST_NORMAL),
            write_row(wpid_pkg::REG_KP_GAIN, 16'hFFFF),
            write_row(wpid_pkg::REG_DEAD_BAND, 16'hFFFF),
            typed_row(16'd300, wpid_pkg::ST_DEAD_BAND),
            write_row(wpid_pkg::REG_ANGLE_LOW, 16'd40000),
            write_row(wpid_pkg::REG_ANGLE_HIGH, 16'd39999),
            typed_row(16'd40000, wpid_pkg::ST_OUT_OF_BAND),
            typed_row(16'd39999, wpid_pkg::ST_OUT_OF_BAND),
            write_row(REG_UNUSED, 16'hA5A5),
            typed_row(16'd0, wpid_pkg::ST_OUT_OF_BAND)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                wait_for_drain();
                write_reg(plan[r].index, plan[r].value);
            end else begin
                cfg_ch.valid <= 1'b0;
                send_angle(plan[r].value, plan[r].typed, plan[r].result);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_drain();
            calm_run = (ph == CALM_PHASE);
            program_phase(ph);
            cfg_ch.valid <= 1'b0;
            if (ph == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            repeat ((ph == EMPTY_PHASE) ? EMPTY_ITEMS : PHASE_ITEMS) begin
                send_angle(next_angle(), 1'b0, '0);
            end
        end

        wait_for_drain();
        calm_run = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("windowed_pid_controller_test OK");
        end else begin
            $display("windowed_pid_controller_test NOT OK");
        end
        $finish;
    end

endmodule
